FILE: rtl/zci_pkg.sv
// shared types and constants of the zero-crossing interpolator
package zci_pkg;

  // sample word width, signed Q16.16 at 32
  localparam int DATA_WIDTH = 32;
  // divider step counter width, one step per quotient bit
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // result kind codes
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_RISE = 2'd1;
  localparam logic [1:0] KIND_FALL = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // input transfer, capture sample and update history
    logic prep;      // form magnitudes and divisor
    logic mul;       // form product, load divider
    logic div_step;  // one restoring division step
    logic push;      // load result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_zero;   // incoming sample has y exactly zero
    logic is_cross;  // incoming sample crosses zero against the held one
    logic slot_free; // result register can take a new result this cycle
  } sts_t;

endpackage

FILE: rtl/zero_crossing_interpolator.sv
// top level of the zero-crossing interpolator
//
// Input channel (in_valid / in_stall) carries samples (x, y) in signed
// Q16.16, with in_start_req marking the first sample of a new function.
// Result channel (out_valid / out_stall) carries the root abscissa and its
// kind: exact zero sample, rising crossing or falling crossing. A sample
// gives at most one result.
// Steps per sample after its input transfer:
//   no zero found: none, the next sample may follow at once
//   exact zero: the result load, then the next sample may follow
//   crossing: operand prep, one 32x32 multiply, a restoring divider
//   producing one quotient bit per cycle, then the result load; the
//   next sample may follow after the result load
// The divider loop sets the throughput for crossings; one sample is in work
// at a time.
// The result register parts the channels: a new sample is taken while a
// result waits. When the receiver stalls and a second result is ready, the
// block holds it and keeps in_stall high until the register frees.
// Synchronous reset clears the history (no previous sample) and empties
// the result register.
module zero_crossing_interpolator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_start_req,
  input  logic [zci_pkg::DATA_WIDTH-1:0] in_sample_x,
  input  logic [zci_pkg::DATA_WIDTH-1:0] in_sample_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [zci_pkg::DATA_WIDTH-1:0] out_root_x,
  output logic [1:0]                     out_root_kind
);
  import zci_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  zci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  zci_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_start_req  (in_start_req),
    .in_sample_x   (in_sample_x),
    .in_sample_y   (in_sample_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_root_x    (out_root_x),
    .out_root_kind (out_root_kind)
  );

  // a crossing transfer holds off the next sample
  a_cross_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !sts.is_zero && sts.is_cross) |=> in_stall)
    else $error("crossing sample did not raise in_stall");

  // a new result only comes from a result load
  a_rose_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.push))
    else $error("out_valid rose without a result load");

  // no arithmetic while ready for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(cmd.mul || cmd.div_step || cmd.prep))
    else $error("datapath busy while accepting input");

  // result load never overwrites a stalled result
  a_push_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.push)
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/zci_ctrl.sv
// controller state machine of the zero-crossing interpolator
module zci_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  zci_pkg::sts_t sts,
  output zci_pkg::cmd_t cmd
);
  import zci_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_PUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic             in_stall_r, in_stall_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.prep     = (state_r == S_PREP);
    cmd.mul      = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    cmd.push     = (state_r == S_PUSH) && sts.slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_zero) begin
            state_nxt = S_PUSH;
          end else if (sts.is_cross) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

FILE: rtl/zci_dp.sv
// datapath of the zero-crossing interpolator: history, multiplier, divider, result
module zci_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  zci_pkg::cmd_t                  cmd,
  output zci_pkg::sts_t                  sts,
  input  logic                           in_start_req,
  input  logic [zci_pkg::DATA_WIDTH-1:0] in_sample_x,
  input  logic [zci_pkg::DATA_WIDTH-1:0] in_sample_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [zci_pkg::DATA_WIDTH-1:0] out_root_x,
  output logic [1:0]                     out_root_kind
);
  import zci_pkg::*;

  localparam int DW = DATA_WIDTH;

  // history
  logic          have_last_r;
  logic [DW-1:0] last_x_r, last_y_r;
  // working sample pair
  logic [DW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic          zero_r;
  // prepared operands
  logic [DW-1:0] a_r, b_r;
  logic [DW:0]   c_r;
  logic          up_r;
  // divider
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] lo_r, lo_nxt;
  // result register
  logic          out_valid_r;
  logic [DW-1:0] root_x_r;
  logic [1:0]    root_kind_r;

  logic          prev;
  logic [DW-1:0] a_nxt, m1_nxt, b_nxt;
  logic          up_nxt;
  logic [2*DW-1:0] prod;
  logic [DW+1:0] trial, diff;
  logic          ge;
  logic [DW-1:0] root_cross;

  // classification of the incoming sample
  assign prev = have_last_r && !in_start_req;
  assign sts.is_zero  = (in_sample_y == '0);
  assign sts.is_cross = prev && (last_y_r != '0) &&
                        (last_y_r[DW-1] != in_sample_y[DW-1]);
  assign sts.slot_free = !out_valid_r || !out_stall;

  // magnitudes, divisor and direction
  assign a_nxt  = y0_r[DW-1] ? (DW'(0) - y0_r) : y0_r;
  assign m1_nxt = y1_r[DW-1] ? (DW'(0) - y1_r) : y1_r;
  assign up_nxt = ($signed(x1_r) >= $signed(x0_r));
  assign b_nxt  = up_nxt ? (x1_r - x0_r) : (x0_r - x1_r);

  // full-width product
  assign prod = (2 * DW)'(a_r) * (2 * DW)'(b_r);

  // restoring division step
  assign trial   = {rem_r, lo_r[DW-1]};
  assign ge      = (trial >= {1'b0, c_r});
  assign diff    = trial - {1'b0, c_r};
  assign rem_nxt = ge ? diff[DW:0] : trial[DW:0];
  assign lo_nxt  = {lo_r[DW-2:0], ge};

  // root from quotient
  assign root_cross = up_r ? (x0_r + lo_r) : (x0_r - lo_r);

  // history and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
    end else if (cmd.accept) begin
      have_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_x_r <= in_sample_x;
      last_y_r <= in_sample_y;
      x0_r     <= last_x_r;
      y0_r     <= last_y_r;
      x1_r     <= in_sample_x;
      y1_r     <= in_sample_y;
      zero_r   <= sts.is_zero;
    end
    if (cmd.prep) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= {1'b0, a_nxt} + {1'b0, m1_nxt};
      up_r <= up_nxt;
    end
    if (cmd.mul) begin
      rem_r <= {1'b0, prod[2*DW-1:DW]};
      lo_r  <= prod[DW-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (zero_r) begin
        root_x_r    <= x1_r;
        root_kind_r <= KIND_ZERO;
      end else begin
        root_x_r    <= root_cross;
        root_kind_r <= y0_r[DW-1] ? KIND_RISE : KIND_FALL;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root_x    = root_x_r;
  assign out_root_kind = root_kind_r;

endmodule
